/* rtl/qau_pkg.sv */
// qau_pkg: request and result types, operation and status codes
// shared by the quaternion arithmetic unit and its cells; no dependencies
package qau_pkg;

  localparam int unsigned WB = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned SQ = 2 * WB + 2;
  localparam int unsigned RB = WB + 1;

  typedef enum logic [2:0] {
    OP_PROD = 3'd0,
    OP_VEC  = 3'd1,
    OP_CONJ = 3'd2,
    OP_LEN  = 3'd3,
    OP_NORM = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } stat_t;

  typedef struct packed {
    logic [2:0]           req_type;
    logic signed [WB-1:0] a_x;
    logic signed [WB-1:0] a_y;
    logic signed [WB-1:0] a_z;
    logic signed [WB-1:0] a_w;
    logic signed [WB-1:0] b_x;
    logic signed [WB-1:0] b_y;
    logic signed [WB-1:0] b_z;
    logic signed [WB-1:0] b_w;
  } req_t;

  typedef struct packed {
    logic signed [WB-1:0] res_x;
    logic signed [WB-1:0] res_y;
    logic signed [WB-1:0] res_z;
    logic signed [WB-1:0] res_w;
    logic [WB-2:0]        res_length;
    logic [1:0]           status;
  } res_t;

  // data handed from one root cell to the next
  typedef struct packed {
    logic                 vld;
    logic [2:0]           op;
    logic [3:0]           neg;
    logic [WB-1:0]        m0;
    logic [WB-1:0]        m1;
    logic [WB-1:0]        m2;
    logic [WB-1:0]        m3;
    logic [SQ-1:0]        rem;
    logic [WB:0]          root;
    logic [WB-1:0]        rx;
    logic [WB-1:0]        ry;
    logic [WB-1:0]        rz;
    logic [WB-1:0]        rw;
    logic                 sat;
  } lane_t;

  // data handed from one divide cell to the next
  typedef struct packed {
    logic                 vld;
    logic [2:0]           op;
    logic [3:0]           neg;
    logic [WB:0]          len;
    logic [3:0][RB-1:0]   rem;
    logic [3:0][WB+FB-1:0] num;
    logic [3:0][WB+FB-1:0] quo;
    logic [WB-1:0]        rx;
    logic [WB-1:0]        ry;
    logic [WB-1:0]        rz;
    logic [WB-1:0]        rw;
    logic                 sat;
  } dlane_t;

endpackage

/* rtl/qau_sqrt_cell.sv */
// qau_sqrt_cell: one restoring square root step, one result bit per cell
// depends on qau_pkg
module qau_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  qau_pkg::lane_t d_in,
  output qau_pkg::lane_t d_out
);
  localparam int unsigned SQ = qau_pkg::SQ;
  localparam int unsigned WB = qau_pkg::WB;

  qau_pkg::lane_t q_nxt, q_r;
  logic [SQ-1:0] trial;

  always_comb begin
    q_nxt = d_in;
    trial = (SQ'({1'b0, d_in.root}) << (BIT + 1)) | (SQ'(1) << (2 * BIT));
    if (d_in.rem >= trial) begin
      q_nxt.rem  = d_in.rem - trial;
      q_nxt.root = d_in.root | ((WB + 1)'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r.vld <= d_in.vld;
    end
    q_r.op   <= q_nxt.op;
    q_r.neg  <= q_nxt.neg;
    q_r.m0   <= q_nxt.m0;
    q_r.m1   <= q_nxt.m1;
    q_r.m2   <= q_nxt.m2;
    q_r.m3   <= q_nxt.m3;
    q_r.rem  <= q_nxt.rem;
    q_r.root <= q_nxt.root;
    q_r.rx   <= q_nxt.rx;
    q_r.ry   <= q_nxt.ry;
    q_r.rz   <= q_nxt.rz;
    q_r.rw   <= q_nxt.rw;
    q_r.sat  <= q_nxt.sat;
  end

  assign d_out = q_r;
endmodule

/* rtl/qau_div_cell.sv */
// qau_div_cell: one restoring divide step for all four components
// depends on qau_pkg
module qau_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  qau_pkg::dlane_t d_in,
  output qau_pkg::dlane_t d_out
);
  localparam int unsigned RB = qau_pkg::RB;
  localparam int unsigned NB = qau_pkg::WB + qau_pkg::FB;

  qau_pkg::dlane_t q_nxt, q_r;
  logic [RB:0] sh;

  always_comb begin
    q_nxt = d_in;
    sh    = '0;
    for (int i = 0; i < 4; i++) begin
      sh = {d_in.rem[i], d_in.num[i][NB-1]};
      q_nxt.num[i] = d_in.num[i] << 1;
      if (sh >= {1'b0, d_in.len}) begin
        q_nxt.rem[i] = RB'(sh - {1'b0, d_in.len});
        q_nxt.quo[i] = {d_in.quo[i][NB-2:0], 1'b1};
      end else begin
        q_nxt.rem[i] = RB'(sh);
        q_nxt.quo[i] = {d_in.quo[i][NB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r.vld <= d_in.vld;
    end
    q_r.op  <= q_nxt.op;
    q_r.neg <= q_nxt.neg;
    q_r.len <= q_nxt.len;
    q_r.rem <= q_nxt.rem;
    q_r.num <= q_nxt.num;
    q_r.quo <= q_nxt.quo;
    q_r.rx  <= q_nxt.rx;
    q_r.ry  <= q_nxt.ry;
    q_r.rz  <= q_nxt.rz;
    q_r.rw  <= q_nxt.rw;
    q_r.sat <= q_nxt.sat;
  end

  assign d_out = q_r;
endmodule

/* rtl/quaternion_arithmetic_unit.sv */
// quaternion_arithmetic_unit: top level, product stages, root and divide cell rows
// depends on qau_pkg, qau_sqrt_cell, qau_div_cell
//
// Usage: drive in_req and raise start; busy is always low, so a request is
// taken in every cycle that start is high. Each request gives exactly one
// result, shown on out_res for one cycle with out_valid high, in request order.
// Each request passes a multiply stage and a sum stage, then WB+1 square
// root cells of one bit each, then WB+FB divide cells of one quotient bit
// each, and last the output register; shift, saturation and result
// selection sit in logic ahead of the root row and the output register.
// Throughput is one request per cycle; every operation walks
// the whole chain so results never reorder. The receiver cannot stall: it
// must take each result in the cycle it is shown. Synchronous reset clears
// all valid flags; nothing in flight survives reset.
//
module quaternion_arithmetic_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  qau_pkg::req_t in_req,
  output logic          out_valid,
  output qau_pkg::res_t out_res
);
  localparam int unsigned WB = qau_pkg::WB;
  localparam int unsigned FB = qau_pkg::FB;
  localparam int unsigned SQ = qau_pkg::SQ;
  localparam int unsigned RB = qau_pkg::RB;
  localparam int unsigned NB = WB + FB;
  localparam int unsigned PB = 2 * WB + 2;
  localparam int unsigned NR = WB + 1;

  typedef logic signed [2*WB-1:0] prod_t;

  assign busy = 1'b0;

  // stage 1: operand magnitudes and sixteen products
  logic          s1_vld_r;
  logic [2:0]    s1_op_r;
  qau_pkg::req_t s1_req_r;
  prod_t         p_r [16];
  logic [2*WB-1:0] sq_r [4];
  logic signed [WB-1:0] bw;
  logic signed [WB-1:0] av [4];
  logic signed [WB-1:0] bv [4];
  logic [WB-1:0] am [4];

  always_comb begin
    bw = (in_req.req_type == qau_pkg::OP_VEC) ? '0 : in_req.b_w;
    av[0] = in_req.a_w; av[1] = in_req.a_x; av[2] = in_req.a_y; av[3] = in_req.a_z;
    bv[0] = bw;         bv[1] = in_req.b_x; bv[2] = in_req.b_y; bv[3] = in_req.b_z;
    for (int i = 0; i < 4; i++) begin
      am[i] = av[i][WB-1] ? WB'(-av[i]) : WB'(av[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    s1_op_r  <= in_req.req_type;
    s1_req_r <= in_req;
    for (int i = 0; i < 4; i++) begin
      sq_r[i] <= am[i] * am[i];
      for (int j = 0; j < 4; j++) begin
        p_r[4*i+j] <= av[i] * bv[j];
      end
    end
  end

  // stage 2: hamilton sums and sum of squares; products index [a*4+b], w=0 x=1 y=2 z=3
  logic          s2_vld_r;
  logic [2:0]    s2_op_r;
  qau_pkg::req_t s2_req_r;
  logic signed [PB-1:0] hw_r, hx_r, hy_r, hz_r;
  logic [SQ-1:0] ss_r;

  function automatic logic signed [PB-1:0] ext(input prod_t p);
    ext = PB'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_op_r  <= s1_op_r;
    s2_req_r <= s1_req_r;
    hw_r <= ext(p_r[0]) - ext(p_r[5]) - ext(p_r[10]) - ext(p_r[15]);
    hx_r <= ext(p_r[4]) + ext(p_r[1]) + ext(p_r[11]) - ext(p_r[14]);
    hy_r <= ext(p_r[8]) + ext(p_r[2]) + ext(p_r[13]) - ext(p_r[7]);
    hz_r <= ext(p_r[12]) + ext(p_r[3]) + ext(p_r[6]) - ext(p_r[9]);
    ss_r <= SQ'(sq_r[0]) + SQ'(sq_r[1]) + SQ'(sq_r[2]) + SQ'(sq_r[3]);
  end

  // stage 3: shift, saturate, conjugate; build root lane
  function automatic logic [WB:0] sat_s(input logic signed [PB-1:0] v);
    logic signed [PB-1:0] mx, mn;
    mx = PB'((65'(1) << (WB - 1)) - 1);
    mn = -mx - 1;
    if (v > mx) sat_s = {1'b1, mx[WB-1:0]};
    else if (v < mn) sat_s = {1'b1, mn[WB-1:0]};
    else sat_s = {1'b0, v[WB-1:0]};
  endfunction

  qau_pkg::lane_t lane [NR+1];
  logic [WB:0] tx, ty, tz, tw;
  logic signed [PB-1:0] cx, cy, cz, cw;
  logic [WB-1:0] mg [4];
  logic [WB-1:0] ra [4];

  always_comb begin
    cx = -PB'(s2_req_r.a_x);
    cy = -PB'(s2_req_r.a_y);
    cz = -PB'(s2_req_r.a_z);
    cw = PB'(s2_req_r.a_w);
    if (s2_op_r == qau_pkg::OP_CONJ) begin
      tx = sat_s(cx); ty = sat_s(cy); tz = sat_s(cz); tw = sat_s(cw);
    end else begin
      tx = sat_s(hx_r >>> FB); ty = sat_s(hy_r >>> FB);
      tz = sat_s(hz_r >>> FB); tw = sat_s(hw_r >>> FB);
    end
    ra[0] = s2_req_r.a_x; ra[1] = s2_req_r.a_y;
    ra[2] = s2_req_r.a_z; ra[3] = s2_req_r.a_w;
    for (int i = 0; i < 4; i++) begin
      mg[i] = ra[i][WB-1] ? WB'(-ra[i]) : ra[i];
    end
    lane[0].vld  = s2_vld_r;
    lane[0].op   = s2_op_r;
    lane[0].neg  = {ra[3][WB-1], ra[2][WB-1], ra[1][WB-1], ra[0][WB-1]};
    lane[0].m0   = mg[0];
    lane[0].m1   = mg[1];
    lane[0].m2   = mg[2];
    lane[0].m3   = mg[3];
    lane[0].rem  = ss_r;
    lane[0].root = '0;
    lane[0].rx   = tx[WB-1:0];
    lane[0].ry   = ty[WB-1:0];
    lane[0].rz   = tz[WB-1:0];
    lane[0].rw   = tw[WB-1:0];
    lane[0].sat  = tx[WB] | ty[WB] | tz[WB] | tw[WB];
  end

  for (genvar g = 0; g < NR; g++) begin : g_sqrt
    qau_sqrt_cell #(.BIT(NR - 1 - g)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_in (lane[g]),
      .d_out(lane[g+1])
    );
  end

  // divide row
  qau_pkg::dlane_t dl [NB+1];
  logic [WB:0] len_nz;

  always_comb begin
    len_nz = (lane[NR].root == '0) ? (WB + 1)'(1) : lane[NR].root;
    dl[0].vld = lane[NR].vld;
    dl[0].op  = lane[NR].op;
    dl[0].neg = lane[NR].neg;
    dl[0].len = len_nz;
    dl[0].rem = '0;
    dl[0].num[0] = {lane[NR].m0, FB'(0)};
    dl[0].num[1] = {lane[NR].m1, FB'(0)};
    dl[0].num[2] = {lane[NR].m2, FB'(0)};
    dl[0].num[3] = {lane[NR].m3, FB'(0)};
    dl[0].quo = '0;
    dl[0].rx  = lane[NR].rx;
    dl[0].ry  = lane[NR].ry;
    dl[0].rz  = lane[NR].rz;
    dl[0].rw  = lane[NR].rw;
    dl[0].sat = lane[NR].sat;
  end

  // root travels alongside the divide row
  logic [WB:0] root_d [NB+1];
  assign root_d[0] = lane[NR].root;

  for (genvar g = 0; g < NB; g++) begin : g_div
    qau_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_in (dl[g]),
      .d_out(dl[g+1])
    );
    always_ff @(posedge clk) begin
      root_d[g+1] <= root_d[g];
    end
  end

  // final stage: select result
  qau_pkg::res_t res_nxt, res_r;
  logic          vld_r;
  logic [WB:0]   root;
  logic [WB-1:0] nq [4];
  logic          nsat;
  logic          lsat;
  logic [NB:0]   mxq;

  always_comb begin
    root = root_d[NB];
    mxq  = (NB + 1)'((65'(1) << (WB - 1)) - 1);
    nsat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (dl[NB].neg[i]) begin
        if ({1'b0, dl[NB].quo[i]} > mxq + 1) begin
          nq[i] = WB'(mxq + 1); nsat = 1'b1;
        end else begin
          nq[i] = WB'(-dl[NB].quo[i]);
        end
      end else if ({1'b0, dl[NB].quo[i]} > mxq) begin
        nq[i] = WB'(mxq); nsat = 1'b1;
      end else begin
        nq[i] = WB'(dl[NB].quo[i]);
      end
    end
    lsat    = root[WB] | root[WB-1];
    res_nxt = '0;
    case (dl[NB].op)
      qau_pkg::OP_PROD, qau_pkg::OP_VEC, qau_pkg::OP_CONJ: begin
        res_nxt.res_x  = dl[NB].rx;
        res_nxt.res_y  = dl[NB].ry;
        res_nxt.res_z  = dl[NB].rz;
        res_nxt.res_w  = dl[NB].rw;
        res_nxt.status = dl[NB].sat ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
      end
      qau_pkg::OP_LEN: begin
        res_nxt.res_length = lsat ? '1 : root[WB-2:0];
        res_nxt.status     = lsat ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
      end
      qau_pkg::OP_NORM: begin
        if (root == '0) begin
          res_nxt.status = qau_pkg::ST_ZERO;
        end else begin
          res_nxt.res_x      = nq[0];
          res_nxt.res_y      = nq[1];
          res_nxt.res_z      = nq[2];
          res_nxt.res_w      = nq[3];
          res_nxt.res_length = lsat ? '1 : root[WB-2:0];
          res_nxt.status     = (lsat | nsat) ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= dl[NB].vld;
    end
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

  logic unused;
  assign unused = ^{lane[NR].rem, dl[NB].rem, dl[NB].num, dl[NB].len, RB'(0)};

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.status != 2'd3)
    else $error("bad status");
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == qau_pkg::ST_ZERO) |-> out_res.res_length == '0)
    else $error("zero length with nonzero length");
endmodule
